>>> design/rhs_pkg.sv
`default_nettype none

package rhs_pkg;

	// default configuration
	localparam int DEPTH_DEF         = 64;
	localparam int KEY_WIDTH_DEF     = 32;
	localparam int PAYLOAD_WIDTH_DEF = 32;

	// one input record as it crosses the port
	typedef struct packed {
		logic signed [31:0] key;
		logic        [31:0] payload;
		logic               last_in;
	} in_item_t;

	// one sorted result as it crosses the port
	typedef struct packed {
		logic signed [31:0] sorted_key;
		logic        [31:0] sorted_payload;
		logic               last_out;
		logic               overflow;
	} out_item_t;

	// sequencer to output register
	typedef struct packed {
		logic load;
		logic last;
		logic overflow;
	} emit_t;

endpackage

`default_nettype wire

>>> design/rhs_ram.sv
`default_nettype none

module rhs_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

>>> design/rhs_ctrl.sv
`default_nettype none

module rhs_ctrl #(
	parameter int DEPTH         = 64,
	parameter int KEY_WIDTH     = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  load_acc,
	input  wire logic                                  load_last,
	input  wire logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0]    load_rec,
	output logic                                       busy,
	input  wire logic                                  out_free,
	output rhs_pkg::emit_t                             emit,
	output logic                                       mem_we,
	output logic      [$clog2(DEPTH)-1:0]              mem_waddr,
	output logic      [KEY_WIDTH+PAYLOAD_WIDTH-1:0]    mem_wdata,
	output logic                                       mem_re,
	output logic      [$clog2(DEPTH)-1:0]              mem_raddr_a,
	output logic      [$clog2(DEPTH)-1:0]              mem_raddr_b,
	input  wire logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0]    mem_rdata_a,
	input  wire logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0]    mem_rdata_b
);

	import rhs_pkg::*;

	localparam int RW = KEY_WIDTH + PAYLOAD_WIDTH;
	localparam int NW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [8:0] {
		ST_LOAD      = 9'b000000001,
		ST_NODE_RD   = 9'b000000010,
		ST_NODE_WAIT = 9'b000000100,
		ST_CHILD     = 9'b000001000,
		ST_CMP       = 9'b000010000,
		ST_SWAP_RD   = 9'b000100000,
		ST_SWAP      = 9'b001000000,
		ST_EMIT_RD   = 9'b010000000,
		ST_EMIT_WAIT = 9'b100000000
	} state_t;

	state_t        state_q, state_d;
	logic [NW-1:0] count_q, count_d;
	logic          dropped_q, dropped_d;
	logic          build_q, build_d;
	logic [NW-1:0] idx_q, idx_d;     // build node or extraction tail
	logic [NW-1:0] node_q, node_d;
	logic [NW-1:0] limit_q, limit_d;
	logic [NW-1:0] k_q, k_d;
	logic [RW-1:0] moving_q, moving_d;

	logic          full;
	logic [NW-1:0] n_next;
	logic [NW:0]   child, child_m1, sel_idx;
	logic [NW-1:0] node_m1, idx_m1, k_m1;
	logic          right_ok;
	logic [RW-1:0] sel_rec;
	logic          stop;
	logic          sift_done;

	function automatic logic signed [KEY_WIDTH-1:0] key_of(input logic [RW-1:0] r);
		return $signed(r[RW-1 -: KEY_WIDTH]);
	endfunction

	assign full     = (count_q == NW'(DEPTH));
	assign n_next   = count_q + {{(NW-1){1'b0}}, !full};
	assign child    = {node_q, 1'b0};
	assign child_m1 = child - (NW+1)'(1);
	assign node_m1  = node_q - NW'(1);
	assign idx_m1   = idx_q - NW'(1);
	assign k_m1     = k_q - NW'(1);
	// right child only when it exists and is strictly larger
	assign right_ok = (child < {1'b0, limit_q})
		&& (key_of(mem_rdata_a) < key_of(mem_rdata_b));
	assign sel_rec  = right_ok ? mem_rdata_b : mem_rdata_a;
	assign sel_idx  = child + {{NW{1'b0}}, right_ok};
	assign stop     = (key_of(moving_q) >= key_of(sel_rec));
	assign busy     = (state_q != ST_LOAD);

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		dropped_d   = dropped_q;
		build_d     = build_q;
		idx_d       = idx_q;
		node_d      = node_q;
		limit_d     = limit_q;
		k_d         = k_q;
		moving_d    = moving_q;
		mem_we      = 1'b0;
		mem_waddr   = node_m1[AW-1:0];
		mem_wdata   = moving_q;
		mem_re      = 1'b0;
		mem_raddr_a = node_m1[AW-1:0];
		mem_raddr_b = child[AW-1:0];
		emit        = '0;
		sift_done   = 1'b0;

		unique case (state_q)
			ST_LOAD: begin
				if (load_acc) begin
					if (!full) begin
						mem_we    = 1'b1;
						mem_waddr = count_q[AW-1:0];
						mem_wdata = load_rec;
					end else begin
						dropped_d = 1'b1;
					end
					count_d = n_next;
					if (load_last) begin
						if (n_next > NW'(1)) begin
							build_d = 1'b1;
							idx_d   = n_next >> 1;
							node_d  = n_next >> 1;
							limit_d = n_next;
							state_d = ST_NODE_RD;
						end else begin
							k_d     = NW'(1);
							state_d = ST_EMIT_RD;
						end
					end
				end
			end
			ST_NODE_RD: begin
				mem_re      = 1'b1;
				mem_raddr_a = node_m1[AW-1:0];
				state_d     = ST_NODE_WAIT;
			end
			ST_NODE_WAIT: begin
				moving_d = mem_rdata_a;
				state_d  = ST_CHILD;
			end
			ST_CHILD: begin
				if (child > {1'b0, limit_q}) begin
					mem_we    = 1'b1;
					mem_wdata = moving_q;
					sift_done = 1'b1;
				end else begin
					mem_re      = 1'b1;
					mem_raddr_a = child_m1[AW-1:0];
					mem_raddr_b = child[AW-1:0];
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				mem_we = 1'b1;
				if (stop) begin
					mem_wdata = moving_q;
					sift_done = 1'b1;
				end else begin
					mem_wdata = sel_rec;
					node_d    = sel_idx[NW-1:0];
					state_d   = ST_CHILD;
				end
			end
			ST_SWAP_RD: begin
				mem_re      = 1'b1;
				mem_raddr_a = '0;
				mem_raddr_b = idx_m1[AW-1:0];
				state_d     = ST_SWAP;
			end
			ST_SWAP: begin
				// old root goes to the tail, the tail record sifts from the root
				mem_we    = 1'b1;
				mem_waddr = idx_m1[AW-1:0];
				mem_wdata = mem_rdata_a;
				moving_d  = mem_rdata_b;
				node_d    = NW'(1);
				limit_d   = idx_m1;
				state_d   = ST_CHILD;
			end
			ST_EMIT_RD: begin
				mem_re      = 1'b1;
				mem_raddr_a = k_m1[AW-1:0];
				state_d     = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (out_free) begin
					emit.load     = 1'b1;
					emit.last     = (k_q == count_q);
					emit.overflow = dropped_q;
					if (k_q == count_q) begin
						count_d   = '0;
						dropped_d = 1'b0;
						state_d   = ST_LOAD;
					end else begin
						k_d     = k_q + NW'(1);
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase

		if (sift_done) begin
			if (build_q) begin
				if (idx_q == NW'(1)) begin
					build_d = 1'b0;
					idx_d   = count_q;
					state_d = ST_SWAP_RD;
				end else begin
					idx_d   = idx_m1;
					node_d  = idx_m1;
					limit_d = count_q;
					state_d = ST_NODE_RD;
				end
			end else if (idx_m1 > NW'(1)) begin
				idx_d   = idx_m1;
				state_d = ST_SWAP_RD;
			end else begin
				k_d     = NW'(1);
				state_d = ST_EMIT_RD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			build_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			dropped_q <= dropped_d;
			build_q   <= build_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		node_q   <= node_d;
		limit_q  <= limit_d;
		k_q      <= k_d;
		moving_q <= moving_d;
	end

endmodule

`default_nettype wire

>>> design/record_heap_sorter.sv
`default_nettype none

// record heap sorter
// input channel rec / rec_valid / rec_stall carries one record per transaction
// (key, payload, last_in). records load one per cycle into a store of DEPTH
// entries; a record that arrives with the store full is dropped and the
// overflow flag of the run is set. the transaction with last_in high closes
// the set, even when that record itself was dropped.
// after last_in the block stalls its input, heapsorts the stored records in a
// single-port-write, dual-read memory and then streams them on the output
// channel sorted / sorted_valid / sorted_stall in ascending key order, with
// last_out on the final one and the same overflow value on all of them.
// each sift-down fetches the moving record first (node read, or root and tail
// read for the swap in extraction), then for each heap level it descends it
// reads both children and does a compare-and-write step, with one more write
// if it reaches a leaf. after the sort the results go out one at a time: each
// is read from memory, then loaded into the output register once it is free.
// a stalling receiver just holds the output register; the sequencer waits.
// reset clears the record count, overflow flag and output valid; memory
// contents are not cleared and need not be.

module record_heap_sorter #(
	parameter int DEPTH         = rhs_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH     = rhs_pkg::KEY_WIDTH_DEF,
	parameter int PAYLOAD_WIDTH = rhs_pkg::PAYLOAD_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rhs_pkg::in_item_t  rec,
	input  wire logic               rec_valid,
	output logic                    rec_stall,
	output rhs_pkg::out_item_t      sorted,
	output logic                    sorted_valid,
	input  wire logic               sorted_stall
);

	import rhs_pkg::*;

	localparam int RW = KEY_WIDTH + PAYLOAD_WIDTH;
	localparam int AW = $clog2(DEPTH);

	logic          busy;
	logic          load_acc;
	logic [RW-1:0] load_rec;
	logic          out_free;
	emit_t         emit;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
	logic [RW-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

	// output register
	out_item_t     out_q;
	logic          out_valid_q;

	logic signed [KEY_WIDTH-1:0] rd_key;
	logic [PAYLOAD_WIDTH-1:0]    rd_payload;

	assign rec_stall    = busy;
	assign load_acc     = rec_valid && !busy;
	// only the low key and payload bits are kept
	assign load_rec     = {rec.key[KEY_WIDTH-1:0], rec.payload[PAYLOAD_WIDTH-1:0]};
	assign out_free     = !out_valid_q || !sorted_stall;
	assign sorted       = out_q;
	assign sorted_valid = out_valid_q;

	assign rd_key     = $signed(mem_rdata_a[RW-1 -: KEY_WIDTH]);
	assign rd_payload = mem_rdata_a[PAYLOAD_WIDTH-1:0];

	rhs_ram #(
		.DEPTH (DEPTH),
		.WIDTH (RW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	rhs_ctrl #(
		.DEPTH         (DEPTH),
		.KEY_WIDTH     (KEY_WIDTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_acc    (load_acc),
		.load_last   (rec.last_in),
		.load_rec    (load_rec),
		.busy        (busy),
		.out_free    (out_free),
		.emit        (emit),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.mem_rdata_a (mem_rdata_a),
		.mem_rdata_b (mem_rdata_b)
	);

	// valid of the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (!sorted_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload loads only when the register is free, so a stalled result holds
	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_q.sorted_key     <= 32'(rd_key);
			out_q.sorted_payload <= 32'(rd_payload);
			out_q.last_out       <= emit.last;
			out_q.overflow       <= emit.overflow;
		end
	end

endmodule

`default_nettype wire

>>> tb/record_heap_checker.sv
`timescale 1ns / 1ps

module record_heap_checker #(
	parameter int DEPTH         = rhs_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH     = rhs_pkg::KEY_WIDTH_DEF,
	parameter int PAYLOAD_WIDTH = rhs_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rhs_pkg::in_item_t  rec,
	input  logic               rec_valid,
	input  logic               rec_stall,
	input  rhs_pkg::out_item_t sorted,
	input  logic               sorted_valid,
	input  logic               sorted_stall,
	output int                 fail_count,
	output int                 pending
);

	localparam logic [31:0] PAYLOAD_MASK = 32'hffffffff >> (32 - PAYLOAD_WIDTH);

	typedef struct {
		logic signed [31:0] key;
		logic        [31:0] payload;
	} record_t;

	// 1-based heap image of the records of the open set
	record_t            heap_mem [1:DEPTH];
	int unsigned        stored_cnt;
	bit                 dropped;
	rhs_pkg::out_item_t sorted_run_q [$];

	record_t            swap_rec;
	rhs_pkg::out_item_t want_item;
	logic        [31:0] key_bits;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] record_heap_checker: %s: got %h, want %h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch(what, got, want);
		end
	endtask

	// right child only wins on a strictly greater key, stop on >=
	function automatic void sift_down(int unsigned node, int unsigned limit);
		record_t     moving;
		int unsigned child;
		moving = heap_mem[node];
		child  = 2 * node;
		while (child <= limit) begin
			if (child < limit && heap_mem[child].key < heap_mem[child + 1].key) begin
				child++;
			end
			if (moving.key >= heap_mem[child].key) begin
				break;
			end
			heap_mem[node] = heap_mem[child];
			node  = child;
			child = 2 * node;
		end
		heap_mem[node] = moving;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			stored_cnt = 0;
			dropped    = 1'b0;
			sorted_run_q.delete();
		end else begin
			// result side
			if (sorted_valid && !sorted_stall) begin
				if (sorted_run_q.size() == 0) begin
					report_mismatch("result with nothing pending", sorted.sorted_key, '0);
				end else begin
					want_item = sorted_run_q.pop_front();
					check_field("sorted_key", sorted.sorted_key, want_item.sorted_key);
					check_field("sorted_payload", sorted.sorted_payload,
						want_item.sorted_payload);
					check_field("last_out", 32'(sorted.last_out), 32'(want_item.last_out));
					check_field("overflow", 32'(sorted.overflow), 32'(want_item.overflow));
				end
			end

			// record side
			if (rec_valid && !rec_stall) begin
				if (stored_cnt < DEPTH) begin
					key_bits = rec.key;
					for (int b = KEY_WIDTH; b < 32; b++) begin
						key_bits[b] = key_bits[KEY_WIDTH - 1];
					end
					stored_cnt++;
					heap_mem[stored_cnt].key     = key_bits;
					heap_mem[stored_cnt].payload = rec.payload & PAYLOAD_MASK;
				end else begin
					dropped = 1'b1;
				end

				if (rec.last_in) begin
					// heap build, then repeated root-to-tail extraction
					for (int unsigned n = stored_cnt / 2; n > 0; n--) begin
						sift_down(n, stored_cnt);
					end
					for (int unsigned t = stored_cnt; t > 1; t--) begin
						swap_rec    = heap_mem[1];
						heap_mem[1] = heap_mem[t];
						heap_mem[t] = swap_rec;
						sift_down(1, t - 1);
					end
					for (int unsigned k = 1; k <= stored_cnt; k++) begin
						want_item.sorted_key     = heap_mem[k].key;
						want_item.sorted_payload = heap_mem[k].payload;
						want_item.last_out       = (k == stored_cnt);
						want_item.overflow       = dropped;
						sorted_run_q.push_back(want_item);
					end
					stored_cnt = 0;
					dropped    = 1'b0;
				end
			end
		end
		pending = sorted_run_q.size();
	end

endmodule

>>> tb/record_heap_sorter_test.sv
`timescale 1ns / 1ps

module record_heap_sorter_test;

	localparam int DEPTH         = rhs_pkg::DEPTH_DEF;
	localparam int KEY_WIDTH     = rhs_pkg::KEY_WIDTH_DEF;
	localparam int PAYLOAD_WIDTH = rhs_pkg::PAYLOAD_WIDTH_DEF;

	// a wide margin over the time a full set of 64 records takes to sort
	localparam int CYCLE_LIMIT   = 400000;
	// quiet time after the last result, enough for a small set to sort and emit
	localparam int SETTLE_CYCLES = 200;
	localparam int PHASE_ITEMS   = 6;

	logic               clk;
	logic               arst_n;
	rhs_pkg::in_item_t  rec;
	logic               rec_valid;
	logic               rec_stall;
	rhs_pkg::out_item_t sorted;
	logic               sorted_valid;
	logic               sorted_stall;

	int fail_count;
	int pending;
	int cycles;

	// idle percentages of the two sides, changed per phase
	int sender_idle_pct;
	int recv_stall_pct;

	record_heap_sorter #(
		.DEPTH        (DEPTH),
		.KEY_WIDTH    (KEY_WIDTH),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (rec),
		.rec_valid   (rec_valid),
		.rec_stall   (rec_stall),
		.sorted      (sorted),
		.sorted_valid(sorted_valid),
		.sorted_stall(sorted_stall)
	);

	// passive watcher: predicts every sorted run and compares it
	record_heap_checker #(
		.DEPTH        (DEPTH),
		.KEY_WIDTH    (KEY_WIDTH),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (rec),
		.rec_valid   (rec_valid),
		.rec_stall   (rec_stall),
		.sorted      (sorted),
		.sorted_valid(sorted_valid),
		.sorted_stall(sorted_stall),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: a hung handshake or a missing result ends here
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("record_heap_sorter regression: fail");
		$finish;
	end

	// receiver: random stall decided at each falling edge
	initial begin
		sorted_stall = 1'b0;
		forever begin
			@(negedge clk);
			sorted_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// keys mix full-range values, a narrow band around zero for many
	// equal keys, and the signed extremes
	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 8)) - 32'd4;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// one record transaction; called at a falling edge, returns at a falling
	// edge after the record was taken. valid and payload hold while stalled
	task automatic send_record(input logic [31:0] key, input logic [31:0] payload,
			input logic last_in);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			rec_valid <= 1'b0;
			@(negedge clk);
		end
		rec.key     <= key;
		rec.payload <= payload;
		rec.last_in <= last_in;
		rec_valid   <= 1'b1;
		@(posedge clk);
		while (rec_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_random_set(input int n);
		for (int i = 0; i < n; i++) begin
			send_record(pick_key(), $urandom, i == n - 1);
		end
	endtask

	// short sets of one to six records, optionally after one set two past capacity
	task automatic run_phase(input int idle_pct, input int stall_pct, input bit overfill);
		int sent;
		int n;
		sent            = 0;
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		// two past capacity: the last two records, the closing one among them, are dropped
		if (overfill) begin
			send_random_set(DEPTH + 2);
		end
		while (sent < PHASE_ITEMS) begin
			n = $urandom_range(1, 6);
			send_random_set(n);
			sent += n;
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		rec             = '0;
		rec_valid       = 1'b0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-record sets at the key and payload extremes
		send_record(32'h8000_0000, 32'h0000_0000, 1'b1);
		send_record(32'h7fff_ffff, 32'hffff_ffff, 1'b1);

		// signed ordering around zero and the extremes
		send_record(32'h0000_0000, 32'h1111_1111, 1'b0);
		send_record(32'hffff_ffff, 32'h2222_2222, 1'b0);
		send_record(32'h7fff_ffff, 32'h3333_3333, 1'b0);
		send_record(32'h8000_0000, 32'h4444_4444, 1'b0);
		send_record(32'h0000_0001, 32'h5555_5555, 1'b1);

		// equal keys: payloads show the order the heap leaves them in
		send_record(32'd5, 32'd1, 1'b0);
		send_record(32'd5, 32'd2, 1'b0);
		send_record(32'd5, 32'd3, 1'b0);
		send_record(-32'sd3, 32'd4, 1'b0);
		send_record(32'd5, 32'd5, 1'b0);
		send_record(-32'sd3, 32'd6, 1'b1);

		// two in reverse order, then three already sorted
		send_record(32'd7, 32'haaaa_aaaa, 1'b0);
		send_record(-32'sd7, 32'h5555_aaaa, 1'b1);
		send_record(32'd1, 32'hdead_0001, 1'b0);
		send_record(32'd2, 32'hdead_0002, 1'b0);
		send_record(32'd3, 32'hdead_0003, 1'b1);

		// random phases: slow receiver with an overfilled set, then slow sender, then full rate
		run_phase(34, 84, 1'b1);
		run_phase(84, 34, 1'b0);
		run_phase(0, 0, 1'b0);

		rec_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		// catch any result that shows up after the last expected one
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("record_heap_sorter regression: pass");
		end else begin
			$display("record_heap_sorter regression: fail");
		end
		$finish;
	end

endmodule
